// ----- rtl/srsm_pkg.sv -----
package srsm_pkg;

    // Relation codes held in the relation register
    typedef enum logic [1:0] {
        REL_EQUAL     = 2'd0,
        REL_SUBSET    = 2'd1,
        REL_SUPERSET  = 2'd2,
        REL_INTERSECT = 2'd3
    } relation_t;

    // Configuration register indexes
    typedef logic [2:0] cfg_index_t;

    localparam cfg_index_t CFG_RELATION     = 3'd0;
    localparam cfg_index_t CFG_SET_COUNT    = 3'd1;
    localparam cfg_index_t CFG_SET_SIZES    = 3'd2;
    localparam cfg_index_t CFG_SET0_MEMBERS = 3'd3;

    // Fixed layout of the configuration words
    localparam int CFG_SETS      = 4;   // sets reachable through the port
    localparam int CFG_SLOTS     = 8;   // member IDs per members word
    localparam int CFG_ID_BITS   = 8;   // bits per packed member ID
    localparam int CFG_SIZE_BITS = 4;   // bits per packed member count
    localparam int CFG_DATA_BITS = 64;

endpackage

// ----- rtl/set_relation_stream_matcher.sv -----
// Set relation stream matcher.
//
// Input channel (elem_valid / elem_stall) carries one ID per request in
// element_id; last_element marks the final ID of a sequence. Each ID is
// compared against up to NUM_SETS configured sets in parallel. Only the
// request marked last produces a result request on the output channel
// (result_valid / result_stall) carrying the one-bit verdict in matched.
// Configuration is written through cfg_valid / cfg_ready / cfg_index /
// cfg_data; cfg_ready is always high. Write only while no sequence is open.
//
// A last ID is held in the input register, and its verdict is loaded into the
// result register when it advances. Throughput: one ID per cycle unless a last ID
// waits on a held result, set by the single compare-and-update stage in between.
// Reset: configuration returns to its reset values, every set flag is set,
// all seen-member and hit bits are cleared, both pipeline registers empty.
// Stall: a held result stalls only a last ID waiting behind it; IDs that are
// not last keep flowing and update the sequence state.
module set_relation_stream_matcher
    import srsm_pkg::*;
#(
    parameter int NUM_SETS     = 4,
    parameter int MAX_SET_SIZE = 8,
    parameter int ID_WIDTH     = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     elem_valid,
    output logic                     elem_stall,
    input  logic [7:0]               element_id,
    input  logic                     last_element,

    output logic                     result_valid,
    input  logic                     result_stall,
    output logic                     matched,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  cfg_index_t               cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int WR_SETS  = (NUM_SETS < CFG_SETS) ? NUM_SETS : CFG_SETS;
    localparam int WR_SLOTS = (MAX_SET_SIZE < CFG_SLOTS) ? MAX_SET_SIZE : CFG_SLOTS;

    // Configuration registers
    relation_t                          relation_reg;
    logic [2:0]                         set_count_reg;
    logic [CFG_SETS*CFG_SIZE_BITS-1:0]  set_sizes_reg;
    logic [ID_WIDTH-1:0]                member_reg [NUM_SETS][MAX_SET_SIZE];

    // Input stage
    logic                               s1_valid_reg;
    logic [ID_WIDTH-1:0]                s1_id_reg;
    logic                               s1_last_reg;

    // Sequence state
    logic [NUM_SETS-1:0]                flags_reg;
    logic [NUM_SETS-1:0]                hit_reg;
    logic [MAX_SET_SIZE-1:0]            seen_reg [NUM_SETS];

    // Result stage
    logic                               result_valid_reg;
    logic                               matched_reg;

    // Combinational update
    logic [MAX_SET_SIZE-1:0]            slot_en   [NUM_SETS];
    logic [MAX_SET_SIZE-1:0]            slot_hit  [NUM_SETS];
    logic [MAX_SET_SIZE-1:0]            seen_next [NUM_SETS];
    logic [NUM_SETS-1:0]                found;
    logic [NUM_SETS-1:0]                flags_next;
    logic [NUM_SETS-1:0]                hit_next;
    logic                               any_eq;
    logic                               any_sub;
    logic                               any_sup;
    logic                               any_int;
    logic                               verdict;
    logic                               s1_advance;
    logic                               elem_accept;
    logic                               cfg_write;

    assign cfg_ready   = 1'b1;
    assign cfg_write   = cfg_valid && cfg_ready;

    // A last ID may leave the input stage only when the result register frees
    assign s1_advance  = s1_valid_reg &&
                         (!s1_last_reg || !result_valid_reg || !result_stall);
    assign elem_stall  = s1_valid_reg && !s1_advance;
    assign elem_accept = elem_valid && !elem_stall;

    // Compare the held ID against every member slot and fold into state
    always_comb
    begin
        for (int s = 0; s < NUM_SETS; s++)
        begin
            for (int k = 0; k < MAX_SET_SIZE; k++)
            begin
                if (s < CFG_SETS)
                begin
                    slot_en[s][k] =
                        (k < int'(set_sizes_reg[s*CFG_SIZE_BITS +: CFG_SIZE_BITS]));
                end
                else
                begin
                    slot_en[s][k] = 1'b0;
                end
                slot_hit[s][k] = slot_en[s][k] && (member_reg[s][k] == s1_id_reg);
            end
            // keep only the lowest matching slot
            seen_next[s] = seen_reg[s] |
                           (slot_hit[s] & (~slot_hit[s] + MAX_SET_SIZE'(1)));
            found[s]     = |slot_hit[s];
        end
        flags_next = flags_reg & found;
        hit_next   = hit_reg | found;

        any_eq  = 1'b0;
        any_sub = 1'b0;
        any_sup = 1'b0;
        any_int = 1'b0;
        for (int s = 0; s < NUM_SETS; s++)
        begin
            if (s < int'(set_count_reg))
            begin
                if (flags_next[s] && ((seen_next[s] & slot_en[s]) == slot_en[s]))
                begin
                    any_eq = 1'b1;
                end
                if (flags_next[s])
                begin
                    any_sub = 1'b1;
                end
                if ((seen_next[s] & slot_en[s]) == slot_en[s])
                begin
                    any_sup = 1'b1;
                end
                if (hit_next[s])
                begin
                    any_int = 1'b1;
                end
            end
        end

        unique case (relation_reg)
            REL_EQUAL:     verdict = any_eq;
            REL_SUBSET:    verdict = any_sub;
            REL_SUPERSET:  verdict = any_sup;
            REL_INTERSECT: verdict = any_int;
            default:       verdict = 1'b0;
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relation_reg  <= REL_EQUAL;
            set_count_reg <= 3'd1;
            set_sizes_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_RELATION)
            begin
                relation_reg <= relation_t'(cfg_data[1:0]);
            end
            if (cfg_index == CFG_SET_COUNT)
            begin
                set_count_reg <= cfg_data[2:0];
            end
            if (cfg_index == CFG_SET_SIZES)
            begin
                set_sizes_reg <= cfg_data[CFG_SETS*CFG_SIZE_BITS-1:0];
            end
        end
    end

    // Member slots: only the first sets and slots are reachable, the rest hold zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SETS; s++)
            begin
                for (int k = 0; k < MAX_SET_SIZE; k++)
                begin
                    member_reg[s][k] <= '0;
                end
            end
        end
        else if (cfg_write)
        begin
            for (int s = 0; s < WR_SETS; s++)
            begin
                if (cfg_index == (CFG_SET0_MEMBERS + cfg_index_t'(s)))
                begin
                    for (int k = 0; k < WR_SLOTS; k++)
                    begin
                        member_reg[s][k] <=
                            ID_WIDTH'(cfg_data[k*CFG_ID_BITS +: CFG_ID_BITS]);
                    end
                end
            end
        end
    end

    // Input stage: load on accept, drop once it advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (elem_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (elem_accept)
        begin
            s1_id_reg   <= ID_WIDTH'(element_id);
            s1_last_reg <= last_element;
        end
    end

    // Sequence state: advance on each ID that is not last, clear on the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '1;
            hit_reg   <= '0;
            for (int s = 0; s < NUM_SETS; s++)
            begin
                seen_reg[s] <= '0;
            end
        end
        else if (s1_advance)
        begin
            if (s1_last_reg)
            begin
                flags_reg <= '1;
                hit_reg   <= '0;
                for (int s = 0; s < NUM_SETS; s++)
                begin
                    seen_reg[s] <= '0;
                end
            end
            else
            begin
                flags_reg <= flags_next;
                hit_reg   <= hit_next;
                for (int s = 0; s < NUM_SETS; s++)
                begin
                    seen_reg[s] <= seen_next[s];
                end
            end
        end
    end

    // Result register: hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (s1_advance && s1_last_reg)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_last_reg)
        begin
            matched_reg <= verdict;
        end
    end

    assign result_valid = result_valid_reg;
    assign matched      = matched_reg;

endmodule

// ----- rtl/srsm_checker.sv -----
module srsm_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       elem_valid,
    input logic       elem_stall,
    input logic       last_element,
    input logic       result_valid,
    input logic       result_stall,
    input logic       matched
);

    // Stalled result holds its verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(matched))
        else $error("result changed while stalled");

    // Input backs up only behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        elem_stall |-> result_valid && result_stall)
        else $error("input stalled without a held result");

    // A last ID yields a result through the input and result registers
    assert property (@(posedge clk) disable iff (!rst_n)
        elem_valid && !elem_stall && last_element |-> ##2 result_valid)
        else $error("verdict missing after last ID");

    // A fresh result always traces back to a last ID
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(elem_valid && !elem_stall && last_element, 2))
        else $error("result without a last ID");

endmodule

bind set_relation_stream_matcher srsm_checker u_srsm_checker (.*);

// ----- tb/set_relation_stream_matcher_tb.sv -----
module set_relation_stream_matcher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srsm_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 4;     // settling margin after the last owed verdict
    localparam int HOLD_CYCLES  = 60;    // long receiver hold-off
    localparam int STALL_LIMIT  = 2000;  // cycles with no request moving on any channel
    localparam int RANDOM_IDS   = 570;

    // Tracks the configuration and the open sequence, and keeps the verdicts
    // still owed by the block in arrival order.
    class verdict_tracker;
        relation_t            relation;
        logic [2:0]           set_count;
        logic [15:0]          set_sizes;
        logic [7:0]           members [CFG_SETS][CFG_SLOTS];
        logic [CFG_SETS-1:0]  only_members;
        logic [CFG_SETS-1:0]  hit;
        logic [CFG_SLOTS-1:0] seen [CFG_SETS];
        bit                   verdicts_due [$];
        int                   errors;

        function new();
            relation  = REL_EQUAL;
            set_count = 3'd1;
            set_sizes = '0;
            foreach (members[s, k])
                members[s][k] = '0;
            errors = 0;
            clear_sequence();
        endfunction

        function void clear_sequence();
            only_members = '1;
            hit          = '0;
            foreach (seen[s])
                seen[s] = '0;
        endfunction

        function int unsigned set_size(int s);
            int unsigned n;
            n = set_sizes[CFG_SIZE_BITS*s +: CFG_SIZE_BITS];
            return (n > CFG_SLOTS) ? CFG_SLOTS : n;
        endfunction

        function void write_register(cfg_index_t index, logic [CFG_DATA_BITS-1:0] data);
            int s;
            s = int'(index) - int'(CFG_SET0_MEMBERS);
            case (index)
                CFG_RELATION:  relation  = relation_t'(data[1:0]);
                CFG_SET_COUNT: set_count = data[2:0];
                CFG_SET_SIZES: set_sizes = data[15:0];
                default:
                begin
                    if (s >= 0 && s < CFG_SETS)
                        for (int k = 0; k < CFG_SLOTS; k++)
                            members[s][k] = data[CFG_ID_BITS*k +: CFG_ID_BITS];
                end
            endcase
        endfunction

        // Update the sequence state with one accepted ID; on the last ID
        // owe a verdict and start over.
        function void take_id(logic [7:0] id, logic last);
            int unsigned          n;
            int unsigned          used;
            logic [CFG_SLOTS-1:0] full;
            bit                   found;
            bit                   all_seen;
            bit                   eq;
            bit                   sub;
            bit                   sup;
            bit                   inter;
            bit                   verdict;
            for (int s = 0; s < CFG_SETS; s++)
            begin
                n     = set_size(s);
                found = 1'b0;
                for (int k = 0; k < n; k++)
                begin
                    if (!found && members[s][k] == id)
                    begin
                        seen[s][k] = 1'b1;
                        found      = 1'b1;
                    end
                end
                if (found)
                    hit[s] = 1'b1;
                else
                    only_members[s] = 1'b0;
            end
            if (!last)
                return;
            used  = (set_count > CFG_SETS) ? CFG_SETS : set_count;
            eq    = 1'b0;
            sub   = 1'b0;
            sup   = 1'b0;
            inter = 1'b0;
            for (int s = 0; s < used; s++)
            begin
                full = '0;
                for (int k = 0; k < set_size(s); k++)
                    full[k] = 1'b1;
                all_seen = ((seen[s] & full) == full);
                eq    |= only_members[s] && all_seen;
                sub   |= only_members[s];
                sup   |= all_seen;
                inter |= hit[s];
            end
            case (relation)
                REL_EQUAL:    verdict = eq;
                REL_SUBSET:   verdict = sub;
                REL_SUPERSET: verdict = sup;
                default:      verdict = inter;
            endcase
            verdicts_due.push_back(verdict);
            clear_sequence();
        endfunction

        function void check_verdict(logic actual);
            bit expected;
            if (verdicts_due.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected verdict, expected none, actual matched=%0b",
                         $time, actual);
            end
            else
            begin
                expected = verdicts_due.pop_front();
                if (actual !== expected)
                begin
                    errors++;
                    $display("%0t ns: matched mismatch, expected %0b, actual %0b",
                             $time, expected, actual);
                end
            end
        endfunction
    endclass

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     elem_valid   = 1'b0;
    logic                     elem_stall;
    logic [7:0]               element_id   = '0;
    logic                     last_element = 1'b0;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    logic                     matched;
    logic                     cfg_valid    = 1'b0;
    logic                     cfg_ready;
    cfg_index_t               cfg_index    = CFG_RELATION;
    logic [CFG_DATA_BITS-1:0] cfg_data     = '0;

    verdict_tracker book;
    int unsigned    send_gap_pct  = 0;  // chance per request of idle cycles on the input
    int unsigned    recv_gap_pct  = 0;  // chance per cycle of a stall on the output
    int unsigned    ids_sent      = 0;
    int unsigned    hold_requests = 0;  // bumped by the stimulus, served by the receiver
    int unsigned    holds_served  = 0;
    int unsigned    quiet_cycles  = 0;

    set_relation_stream_matcher dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .elem_valid   (elem_valid),
        .elem_stall   (elem_stall),
        .element_id   (element_id),
        .last_element (last_element),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .matched      (matched),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Monitor: every handshake is judged on the values held just before the
    // edge, since all drivers update through nonblocking assignments.
    // Note accepted IDs, check accepted verdicts, mirror register writes,
    // and stop the run if no channel moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cfg_valid && cfg_ready) || (elem_valid && !elem_stall) ||
                (result_valid && !result_stall))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (cfg_valid && cfg_ready)
            begin
                book.write_register(cfg_index, cfg_data);
            end
            if (elem_valid && !elem_stall)
            begin
                book.take_id(element_id, last_element);
            end
            if (result_valid && !result_stall)
            begin
                book.check_verdict(matched);
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t ns: no request moved for %0d cycles", $time, STALL_LIMIT);
                $display("set_relation_stream_matcher verification failed");
                $finish;
            end
        end
    end

    // Receiver: stall at random, or hold off for a long stretch whenever the
    // stimulus asks, so that a last ID waits behind the held verdict and the input backs up.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                repeat (HOLD_CYCLES)
                begin
                    result_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            result_stall <= ($urandom_range(99) < recv_gap_pct);
        end
    end

    // Offer one ID and hold it until it is accepted. Leave valid high on
    // return so that back-to-back requests need no extra assignment.
    task automatic send_id(input logic [7:0] id, input logic last);
        while ($urandom_range(99) < send_gap_pct)
        begin
            elem_valid <= 1'b0;
            @(posedge clk);
        end
        elem_valid   <= 1'b1;
        element_id   <= id;
        last_element <= last;
        do
            @(posedge clk);
        while (elem_stall);
        ids_sent++;
    endtask

    // Drop the input and wait until every owed verdict has come back, then
    // give the block a few cycles to settle.
    task automatic drain();
        elem_valid <= 1'b0;
        do
            @(posedge clk);
        while (book.verdicts_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t index, input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Write every register; only ever done with the block idle.
    task automatic configure(input relation_t rel, input logic [2:0] count,
                             input logic [15:0] sizes,
                             input logic [CFG_SETS-1:0][CFG_DATA_BITS-1:0] m);
        drain();
        write_reg(CFG_RELATION, CFG_DATA_BITS'(rel));
        write_reg(CFG_SET_COUNT, CFG_DATA_BITS'(count));
        write_reg(CFG_SET_SIZES, CFG_DATA_BITS'(sizes));
        for (int s = 0; s < CFG_SETS; s++)
            write_reg(cfg_index_t'(CFG_SET0_MEMBERS + s), m[s]);
        cfg_valid <= 1'b0;
    endtask

    // Mostly sane settings: counts in range, sizes up to eight, random
    // members. Now and then push counts and sizes past their range, squeeze
    // members into a narrow pool so they repeat and overlap, or go to the
    // all-zeros and all-ones extremes.
    task automatic random_configure();
        relation_t                                rel;
        logic [2:0]                               count;
        logic [15:0]                              sizes;
        logic [CFG_SETS-1:0][CFG_DATA_BITS-1:0]   m;
        bit                                       extreme;
        bit                                       narrow;
        rel     = relation_t'($urandom_range(3));
        extreme = ($urandom_range(5) == 0);
        count   = ($urandom_range(4) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4, 1));
        for (int s = 0; s < CFG_SETS; s++)
        begin
            sizes[CFG_SIZE_BITS*s +: CFG_SIZE_BITS] =
                ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
            narrow = ($urandom_range(3) == 0);
            for (int k = 0; k < CFG_SLOTS; k++)
                m[s][CFG_ID_BITS*k +: CFG_ID_BITS] =
                    narrow ? 8'($urandom_range(15)) : 8'($urandom);
        end
        if (extreme)
        begin
            count = $urandom_range(1) ? 3'd7 : 3'd0;
            case ($urandom_range(2))
                0:       sizes = 16'h0000;
                1:       sizes = 16'hFFFF;
                default: sizes = 16'h8888;
            endcase
            for (int s = 0; s < CFG_SETS; s++)
                if ($urandom_range(1))
                    m[s] = $urandom_range(1) ? '1 : '0;
        end
        configure(rel, count, sizes, m);
    endtask

    // Build one sequence around a chosen set: mostly its members in shuffled
    // order, sometimes a prefix only, a repeated member or a foreign ID
    // slipped in; the rest is plain random noise.
    task automatic send_sequence();
        logic [7:0]  ids [$];
        logic [7:0]  tmp;
        int unsigned target;
        int unsigned n;
        int unsigned j;
        int unsigned kind;
        target = $urandom_range(CFG_SETS - 1);
        n      = book.set_size(target);
        kind   = $urandom_range(9);
        if (kind < 8)
        begin
            for (int k = 0; k < n; k++)
                ids.push_back(book.members[target][k]);
            for (int k = int'(ids.size()) - 1; k > 0; k--)
            begin
                j      = $urandom_range(k);
                tmp    = ids[k];
                ids[k] = ids[j];
                ids[j] = tmp;
            end
            if (kind >= 5 && ids.size() > 1)
                repeat ($urandom_range(ids.size() - 1)) void'(ids.pop_back());
            if ((kind == 3 || kind == 6) && ids.size() > 0)
                ids.push_back(ids[$urandom_range(ids.size() - 1)]);
            if (kind == 7)
                ids.insert($urandom_range(ids.size()), 8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(6, 1)) ids.push_back(8'($urandom));
        end
        if (ids.size() == 0)
            ids.push_back(8'($urandom));
        foreach (ids[i])
            send_id(ids[i], i == ids.size() - 1);
    endtask

    initial
    begin
        int unsigned phase_end;
        int unsigned block_end;
        book = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset settings first: set 0 is empty, so the first
        // ID clears its flag and equality fails.
        send_id(8'h00, 1'b1);

        // An empty set is trivially covered: superset holds.
        configure(REL_SUPERSET, 3'd1, 16'h0000, '0);
        send_id(8'hFF, 1'b1);

        // Two small sets: {00, FF, 5A} and {A5, 00}.
        configure(REL_EQUAL, 3'd2, 16'h0023,
                  {64'h0, 64'h0, 64'h0000_0000_0000_00A5, 64'h0000_0000_005A_FF00});
        send_id(8'hFF, 1'b0);
        send_id(8'h00, 1'b0);
        send_id(8'h5A, 1'b1);
        send_id(8'hA5, 1'b0);
        send_id(8'h00, 1'b1);
        send_id(8'h00, 1'b1);

        configure(REL_SUBSET, 3'd2, 16'h0023,
                  {64'h0, 64'h0, 64'h0000_0000_0000_00A5, 64'h0000_0000_005A_FF00});
        send_id(8'h00, 1'b0);
        send_id(8'h00, 1'b1);
        send_id(8'h5A, 1'b0);
        send_id(8'hA5, 1'b1);

        configure(REL_INTERSECT, 3'd2, 16'h0023,
                  {64'h0, 64'h0, 64'h0000_0000_0000_00A5, 64'h0000_0000_005A_FF00});
        send_id(8'h11, 1'b0);
        send_id(8'h22, 1'b1);
        send_id(8'h11, 1'b0);
        send_id(8'hA5, 1'b1);

        // No sets in use: always no match.
        configure(REL_INTERSECT, 3'd0, 16'h0023,
                  {64'h0, 64'h0, 64'h0000_0000_0000_00A5, 64'h0000_0000_005A_FF00});
        send_id(8'h00, 1'b1);

        // Count and sizes past their range; set 0 repeats one member so it
        // can never be fully seen, set 3 holds 00..07.
        configure(REL_EQUAL, 3'd7, 16'hF999,
                  {64'h0706_0504_0302_0100, {$urandom, $urandom}, {$urandom, $urandom},
                   64'hFFFF_FFFF_FFFF_FFFF});
        for (int i = 0; i < CFG_SLOTS; i++)
            send_id(8'(i), i == CFG_SLOTS - 1);

        // Random part in three idling modes: sender rarely idle and receiver
        // often, then the reverse, then full speed with one long hold-off.
        for (int mode = 0; mode < 3; mode++)
        begin
            send_gap_pct = (mode == 0) ? 9 : (mode == 1) ? 55 : 0;
            recv_gap_pct = (mode == 0) ? 55 : (mode == 1) ? 9 : 0;
            phase_end    = ids_sent + RANDOM_IDS / 3;
            while (ids_sent < phase_end)
            begin
                random_configure();
                block_end = ids_sent + $urandom_range(50, 25);
                if (mode == 2 && hold_requests == 0)
                    hold_requests <= hold_requests + 1;
                while (ids_sent < block_end)
                    send_sequence();
            end
        end

        drain();
        if (book.errors == 0)
            $display("set_relation_stream_matcher verification clean");
        else
            $display("set_relation_stream_matcher verification failed");
        $finish;
    end

endmodule
